[rtl/bfc_pkg.sv]
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types, command codes and register indexes of the backlight fade
// controller.
// ----------------------------------------------------------------------------
package bfc_pkg;

  localparam int LevelW = 7;
  localparam int ReqW   = 8;
  localparam int OpW    = 2;
  localparam int CfgIdxW = 3;
  localparam int QuoW   = 7;   // quotient never exceeds the 7-bit level diff
  localparam int DivSelW = 3;

  typedef logic [LevelW-1:0] level_t;
  typedef logic [OpW-1:0]    op_t;

  // command codes
  localparam op_t OP_TICK    = 2'd0;
  localparam op_t OP_SET     = 2'd1;
  localparam op_t OP_FADE    = 2'd2;
  localparam op_t OP_RESTORE = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_MIN_LEVEL   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_LEVEL   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LOW_BATTERY = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SAVED_LEVEL = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DIM_ENABLE  = 3'd4;

  // reset values
  localparam level_t RST_MIN_LEVEL   = 7'd0;
  localparam level_t RST_MAX_LEVEL   = 7'd100;
  localparam level_t RST_LOW_BATTERY = 7'd20;
  localparam level_t RST_SAVED_LEVEL = 7'd100;
  localparam level_t RST_CUR_LEVEL   = 7'd100;

  typedef struct packed {
    logic                load_in;
    logic                exec;
    logic                tick_inc;
    logic                apply_target;
    logic                mul;
    logic                div_step;
    logic [DivSelW-1:0]  div_sel;
    logic                apply_step;
    logic                bat;
    logic                out_load;
  } bfc_cmd_t;

  typedef struct packed {
    op_t  op;
    logic fading;
    logic reached;
  } bfc_status_t;

  // when the limits cross, a value below min gets min and any other gets max
  function automatic level_t clamp_level(input logic [ReqW-1:0] v,
                                         input level_t lo, input level_t hi);
    level_t res;
    if (v < {1'b0, lo}) begin
      res = lo;
    end else if (v > {1'b0, hi}) begin
      res = hi;
    end else begin
      res = v[LevelW-1:0];
    end
    return res;
  endfunction

endpackage

[rtl/bfc_ctrl.sv]
// ----------------------------------------------------------------------------
// bfc_ctrl
// Sequencer: executes a set, fade or restore word, or steps a tick through
// fade update, multiply and divide (mid-fade), battery rule; then output load.
// ----------------------------------------------------------------------------
module bfc_ctrl import bfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  bfc_status_t sts,
  output bfc_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_TICK = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_STEP = 3'd5;
  localparam logic [2:0] S_BAT  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  localparam logic [DivSelW-1:0] DIV_FIRST = DivSelW'(QuoW - 1);

  logic [2:0]         state_r, state_nxt;
  logic [DivSelW-1:0] cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    cmd.div_sel   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.op == OP_TICK) begin
          state_nxt = S_TICK;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_TICK: begin
        if (!sts.fading) begin
          state_nxt = S_BAT;
        end else if (sts.reached) begin
          cmd.tick_inc     = 1'b1;
          cmd.apply_target = 1'b1;
          state_nxt        = S_BAT;
        end else begin
          cmd.tick_inc = 1'b1;
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = DIV_FIRST;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        cmd.apply_step = 1'b1;
        state_nxt      = S_BAT;
      end
      S_BAT: begin
        cmd.bat   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/bfc_datapath.sv]
// ----------------------------------------------------------------------------
// bfc_datapath
// Level state, limit registers, fade interpolation (multiply then
// restoring divide, one quotient bit per cycle) and output register.
// ----------------------------------------------------------------------------
module bfc_datapath import bfc_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CfgIdxW-1:0]    cfg_index,
  input  logic [LevelW-1:0]     cfg_wdata,
  input  logic [OpW-1:0]        in_operation,
  input  logic [ReqW-1:0]       in_level_request,
  input  logic [TIME_WIDTH-1:0] in_fade_length,
  input  logic                  in_dim_request,
  input  bfc_cmd_t              cmd,
  output bfc_status_t           sts,
  output logic [LevelW-1:0]     out_level_out,
  output logic                  out_fade_active
);

  localparam int ProdW = TIME_WIDTH + QuoW;

  // configuration
  level_t min_r, max_r, low_r, saved_r;
  logic   dim_en_r;

  // latched command word
  op_t                   op_r;
  logic [ReqW-1:0]       req_r;
  logic [TIME_WIDTH-1:0] len_r;
  logic                  dim_r;

  // fade state
  level_t                cur_r, cur_nxt;
  logic                  fading_r, fading_nxt;
  level_t                start_r, start_nxt;
  level_t                target_r, target_nxt;
  logic [TIME_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic [TIME_WIDTH-1:0] length_r, length_nxt;

  // divider
  logic [ProdW-1:0] prod_r, prod_nxt;
  logic [QuoW-1:0]  quo_r, quo_nxt;

  level_t                out_level_r;
  logic                  out_fade_r;

  logic                  up;
  level_t                mag;
  logic [TIME_WIDTH-1:0] elapsed_inc;
  logic [ProdW-1:0]      dvs;
  logic                  ge;
  level_t                step_lvl;

  assign up          = (target_r >= start_r);
  assign mag         = up ? (target_r - start_r) : (start_r - target_r);
  // saturating elapsed count
  assign elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + 1'b1;
  assign dvs         = {{QuoW{1'b0}}, length_r} << cmd.div_sel;
  assign ge          = (prod_r >= dvs);
  assign step_lvl    = up ? (start_r + quo_r) : (start_r - quo_r);

  assign sts.op      = op_r;
  assign sts.fading  = fading_r;
  assign sts.reached = (elapsed_inc >= length_r);

  assign out_level_out   = out_level_r;
  assign out_fade_active = out_fade_r;

  always_comb begin
    cur_nxt     = cur_r;
    fading_nxt  = fading_r;
    start_nxt   = start_r;
    target_nxt  = target_r;
    elapsed_nxt = elapsed_r;
    length_nxt  = length_r;
    prod_nxt    = prod_r;
    quo_nxt     = quo_r;

    if (cmd.exec) begin
      unique case (op_r)
        OP_SET: begin
          cur_nxt    = clamp_level(req_r, min_r, max_r);
          fading_nxt = 1'b0;
        end
        OP_FADE: begin
          target_nxt  = clamp_level(req_r, min_r, max_r);
          start_nxt   = cur_r;
          elapsed_nxt = '0;
          length_nxt  = len_r;
          fading_nxt  = 1'b1;
        end
        OP_RESTORE: begin
          cur_nxt    = clamp_level({1'b0, saved_r}, min_r, max_r);
          fading_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.tick_inc) begin
      elapsed_nxt = elapsed_inc;
    end
    if (cmd.apply_target) begin
      cur_nxt    = clamp_level({1'b0, target_r}, min_r, max_r);
      fading_nxt = 1'b0;
    end

    if (cmd.mul) begin
      prod_nxt = {{TIME_WIDTH{1'b0}}, mag} * {{QuoW{1'b0}}, elapsed_r};
      quo_nxt  = '0;
    end
    if (cmd.div_step) begin
      prod_nxt = ge ? (prod_r - dvs) : prod_r;
      quo_nxt  = {quo_r[QuoW-2:0], ge};
    end
    if (cmd.apply_step) begin
      cur_nxt = clamp_level({1'b0, step_lvl}, min_r, max_r);
    end

    // battery rule
    if (cmd.bat && dim_en_r) begin
      if (dim_r) begin
        if (cur_r > low_r) begin
          cur_nxt    = clamp_level({1'b0, low_r}, min_r, max_r);
          fading_nxt = 1'b0;
        end
      end else if (cur_r == low_r) begin
        cur_nxt    = clamp_level({1'b0, saved_r}, min_r, max_r);
        fading_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r     <= RST_MIN_LEVEL;
      max_r     <= RST_MAX_LEVEL;
      low_r     <= RST_LOW_BATTERY;
      saved_r   <= RST_SAVED_LEVEL;
      dim_en_r  <= 1'b0;
      cur_r     <= RST_CUR_LEVEL;
      fading_r  <= 1'b0;
      start_r   <= '0;
      target_r  <= '0;
      elapsed_r <= '0;
      length_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_MIN_LEVEL:   min_r    <= cfg_wdata;
          REG_MAX_LEVEL:   max_r    <= cfg_wdata;
          REG_LOW_BATTERY: low_r    <= cfg_wdata;
          REG_SAVED_LEVEL: saved_r  <= cfg_wdata;
          REG_DIM_ENABLE:  dim_en_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      cur_r     <= cur_nxt;
      fading_r  <= fading_nxt;
      start_r   <= start_nxt;
      target_r  <= target_nxt;
      elapsed_r <= elapsed_nxt;
      length_r  <= length_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_operation;
      req_r <= in_level_request;
      len_r <= in_fade_length;
      dim_r <= in_dim_request;
    end
    prod_r <= prod_nxt;
    quo_r  <= quo_nxt;
    if (cmd.out_load) begin
      out_level_r <= cur_r;
      out_fade_r  <= fading_r;
    end
  end

endmodule

[rtl/backlight_fade_controller.sv]
// ----------------------------------------------------------------------------
// backlight_fade_controller
// Backlight level controller with linear fades and battery dimming.
// ----------------------------------------------------------------------------
// Each input word is one command: a 1 ms tick, set level, start fade or
// restore the saved level. Every accepted word gives exactly one output word
// with the level in percent and the fade flag after that command.
// Input: in_valid/in_stall, accepted when in_valid is high and in_stall low.
// Output: out_valid/out_stall, held steady while out_stall is high.
// Configuration: cfg_wr_en writes cfg_wdata to the register at cfg_index;
// callers must write only while no command is in flight (not enforced).
// Sequence: set, fade start and restore are executed, then output-loaded;
// a tick runs the fade update, then in the middle of a fade the 7 x
// TIME_WIDTH multiply, the 7-bit restoring divide (one quotient bit a cycle)
// and the step update, then the battery rule and output load.
// One command is processed at a time; the next one is taken once the
// previous result sits in the output register, and a stalled receiver
// holds back at most one further command.
// Reset (rst_n, synchronous): level 100, no fade, registers at defaults.
// ----------------------------------------------------------------------------
module backlight_fade_controller import bfc_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [LevelW-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OpW-1:0]       in_operation,
  input  logic [ReqW-1:0]      in_level_request,
  input  logic [31:0]          in_fade_length_ms,
  input  logic                 in_dim_request,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LevelW-1:0]    out_level_out,
  output logic                 out_fade_active
);

  bfc_cmd_t    cmd;
  bfc_status_t sts;

  bfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfc_datapath #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_operation     (in_operation),
    .in_level_request (in_level_request),
    .in_fade_length   (in_fade_length_ms[TIME_WIDTH-1:0]),
    .in_dim_request   (in_dim_request),
    .cmd              (cmd),
    .sts              (sts),
    .out_level_out    (out_level_out),
    .out_fade_active  (out_fade_active)
  );

endmodule
